FILE: design/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_pkg
// Shared constants, codes and a helper function of the Jacobi eigen block.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int WORD_BITS = 32;
	localparam int SWEEP_W   = 7;
	localparam int THR_W     = 32;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;
	localparam int OFF_W     = 52;

	localparam logic [DIM_W-1:0]   SIZE_RST   = DIM_W'(MAX_DIM);
	localparam logic [SWEEP_W-1:0] SWEEPS_RST = SWEEP_W'(100);
	localparam logic signed [WORD_BITS-1:0] ONE_Q30 = WORD_BITS'(1 << 30);

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_MATRIX_SIZE   = 2'd0,
		REG_MAX_SWEEPS    = 2'd1,
		REG_OFF_THRESHOLD = 2'd2
	} reg_idx_t;

	// which store and orientation a rotation pass works on
	typedef enum logic [1:0] {
		PH_COL,
		PH_ROW,
		PH_VEC
	} rot_phase_t;

	typedef enum logic [5:0] {
		S_IDLE, S_INIT, S_SWEEP_CHK,
		S_OFF_RD, S_OFF_MUL, S_OFF_ACC, S_OFF_CMP,
		S_ROT_RD0, S_ROT_RD1, S_ROT_RD2, S_ROT_DE, S_ROT_DD, S_ROT_EE,
		S_H_LOAD, S_H_SQRT, S_T_LOAD, S_T_DIV, S_ROT_TT,
		S_R_LOAD, S_R_SQRT, S_C_LOAD, S_C_DIV, S_ROT_TC, S_ROT_S,
		S_RT_RDX, S_RT_RDY, S_RT_CAP, S_RT_M1, S_RT_M2, S_RT_M3, S_RT_M4,
		S_RT_WX, S_RT_WY,
		S_OUT_RD, S_OUT_LD, S_OUT_HOLD
	} jse_state_t;

	// divide by 2^30, round half away from zero, saturate to a store word
	function automatic logic signed [WORD_BITS-1:0] rnd_sat(input logic signed [63:0] x);
		logic [63:0] m;
		logic [33:0] mq;
		logic signed [35:0] v;
		m  = x[63] ? 64'(-x) : 64'(x);
		m  = m + (64'd1 << 29);
		mq = m[63:30];
		v  = x[63] ? -$signed({2'b00, mq}) : $signed({2'b00, mq});
		if (v > 36'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			return 32'sh80000000;
		else
			return v[WORD_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/jse_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jse_if
// Element request channel and result request channel of the eigen block.
// ----------------------------------------------------------------------------
interface jse_in_if;
	logic                                   valid;
	logic                                   ready;
	logic        [jse_pkg::IDX_W-1:0]       elem_row;
	logic        [jse_pkg::IDX_W-1:0]       elem_col;
	logic signed [jse_pkg::WORD_BITS-1:0]   elem_value;
	logic                                   load_last;

	modport source (output valid, elem_row, elem_col, elem_value, load_last, input ready);
	modport sink   (input valid, elem_row, elem_col, elem_value, load_last, output ready);
endinterface

interface jse_out_if;
	logic                                   valid;
	logic                                   ready;
	logic        [jse_pkg::IDX_W-1:0]       vec_row;
	logic        [jse_pkg::IDX_W-1:0]       vec_col;
	logic signed [jse_pkg::WORD_BITS-1:0]   eigen_value;
	logic signed [jse_pkg::WORD_BITS-1:0]   vector_value;
	logic                                   converged;
	logic        [jse_pkg::SWEEP_W-1:0]     sweeps_used;
	logic                                   out_last;

	modport source (output valid, vec_row, vec_col, eigen_value, vector_value, converged,
		sweeps_used, out_last, input ready);
	modport sink   (input valid, vec_row, vec_col, eigen_value, vector_value, converged,
		sweeps_used, out_last, output ready);
endinterface
`default_nettype wire

FILE: design/jacobi_symmetric_eigen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_symmetric_eigen
// Cyclic Jacobi eigen decomposition of a symmetric matrix of up to 8x8.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle into the matrix RAM; the element flagged
// load_last starts a run and the element channel then stays not ready until
// every result has been delivered. A run writes the identity into the
// eigenvector RAM, then for each sweep sums the off-diagonal squares and
// rotates every nonzero pair, skipping a zero pair. A rotation runs two
// square roots of 32 steps and two divisions of 64 steps on the shared
// iterative units, then three passes of n read-modify-write steps over the
// RAMs (one read and one write port each) through one shared multiplier.
// Results leave through a registered output one at a time, the next being
// read only once the last is taken, eigenvector by eigenvector with rows
// ascending.
// ----------------------------------------------------------------------------
module jacobi_symmetric_eigen (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	jse_in_if.sink                           elem,
	jse_out_if.source                        result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [jse_pkg::APB_AW-1:0]  paddr,
	input  wire logic [jse_pkg::APB_DW-1:0]  pwdata,
	output logic      [jse_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);
	import jse_pkg::*;

	// configuration
	logic [DIM_W-1:0]   matrix_size_q;
	logic [SWEEP_W-1:0] max_sweeps_q;
	logic [THR_W-1:0]   off_threshold_q;
	logic               cfg_we;
	logic [DIM_W-1:0]   n;

	// storage
	logic signed [WORD_BITS-1:0] matrix_store_q [MAX_DIM*MAX_DIM];
	logic signed [WORD_BITS-1:0] vector_store_q [MAX_DIM*MAX_DIM];
	logic signed [WORD_BITS-1:0] mat_rd_q, vec_rd_q;
	logic                        mat_we, vec_we;
	logic [ADDR_W-1:0]           mat_waddr, vec_waddr, mat_raddr, vec_raddr;
	logic signed [WORD_BITS-1:0] mat_wdata, vec_wdata;

	jse_state_t state_q, state_d;

	// loop and run control
	logic [DIM_W-1:0]   p_q, q_q, k_q, i_q, j_q;
	rot_phase_t         ph_q;
	logic [SWEEP_W-1:0] sweep_q;
	logic               conv_q;
	logic [OFF_W-1:0]   off_q;
	logic [5:0]         cnt_q;

	// rotation arithmetic
	logic signed [WORD_BITS-1:0] apq_q, aqq_q, xa_q, yb_q;
	logic [29:0]                 dd_q, ee_q;
	logic                        neg_q;
	logic [30:0]                 t_q, c_q;
	logic signed [WORD_BITS-1:0] s_q;
	logic signed [63:0]          prod_q, acc_q, xsum_q, ysum_q;
	logic [63:0]                 sqacc_q;
	logic signed [32:0]          mul_a, mul_b;
	logic signed [65:0]          mul_full;

	// square root and divider units
	logic [63:0] sq_v_q, sq_r_q, sq_bit_q, sq_trial;
	logic        sq_ge, sq_done;
	logic [63:0] nm_q;
	logic [31:0] den_q;
	logic [32:0] rem_q, rem_sh;
	logic        dv_ge, dv_done;

	// pair and loop bookkeeping
	logic more_q, more_p, more_k, more_i;
	logic signed [WORD_BITS-1:0] rt_rd;
	logic [ADDR_W-1:0]           x_addr, y_addr;

	// rotation step helpers
	logic signed [32:0] d_w, e_w;
	logic [32:0]        dm_w, em_w, de_or;
	logic [1:0]         sh_w;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q   <= SIZE_RST;
			max_sweeps_q    <= SWEEPS_RST;
			off_threshold_q <= '0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_MATRIX_SIZE:   matrix_size_q   <= pwdata[DIM_W-1:0];
				REG_MAX_SWEEPS:    max_sweeps_q    <= pwdata[SWEEP_W-1:0];
				REG_OFF_THRESHOLD: off_threshold_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MATRIX_SIZE:   prdata = APB_DW'(matrix_size_q);
			REG_MAX_SWEEPS:    prdata = APB_DW'(max_sweeps_q);
			REG_OFF_THRESHOLD: prdata = APB_DW'(off_threshold_q);
			default:           prdata = '0;
		endcase
	end

	// clamp the size into 1..MAX_DIM
	assign n = (matrix_size_q == '0) ? DIM_W'(1) :
		(matrix_size_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : matrix_size_q;

	// ---------------------------------------------------------------- memories
	always_ff @(posedge clk) begin
		if (mat_we)
			matrix_store_q[mat_waddr] <= mat_wdata;
		mat_rd_q <= matrix_store_q[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (vec_we)
			vector_store_q[vec_waddr] <= vec_wdata;
		vec_rd_q <= vector_store_q[vec_raddr];
	end

	// ---------------------------------------------------------------- helpers
	assign more_q = (q_q + DIM_W'(1)) < n;
	assign more_p = (p_q + DIM_W'(2)) < n;
	assign more_k = (k_q + DIM_W'(1)) < n;
	assign more_i = (i_q + DIM_W'(1)) < n;

	assign x_addr = (ph_q == PH_ROW) ? {p_q[IDX_W-1:0], k_q[IDX_W-1:0]}
		: {k_q[IDX_W-1:0], p_q[IDX_W-1:0]};
	assign y_addr = (ph_q == PH_ROW) ? {q_q[IDX_W-1:0], k_q[IDX_W-1:0]}
		: {k_q[IDX_W-1:0], q_q[IDX_W-1:0]};
	assign rt_rd  = (ph_q == PH_VEC) ? vec_rd_q : mat_rd_q;

	// shared multiplier, registered
	assign mul_full = mul_a * mul_b;

	// square root step
	assign sq_trial = sq_r_q + sq_bit_q;
	assign sq_ge    = sq_v_q >= sq_trial;
	assign sq_done  = sq_bit_q == 64'd1;

	// restoring divider step
	assign rem_sh  = {rem_q[31:0], nm_q[63]};
	assign dv_ge   = rem_sh >= {1'b0, den_q};
	assign dv_done = cnt_q == 6'd63;

	// difference, doubled off-diagonal and their common scaling
	assign d_w   = {aqq_q[WORD_BITS-1], aqq_q} - {mat_rd_q[WORD_BITS-1], mat_rd_q};
	assign e_w   = {apq_q, 1'b0};
	assign dm_w  = d_w[32] ? 33'(-d_w) : 33'(d_w);
	assign em_w  = e_w[32] ? 33'(-e_w) : 33'(e_w);
	assign de_or = dm_w | em_w;
	assign sh_w  = de_or[32] ? 2'd3 : de_or[31] ? 2'd2 : de_or[30] ? 2'd1 : 2'd0;

	// ---------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state, memory ports, multiplier operands, handshakes
	always_comb begin
		state_d      = state_q;
		elem.ready   = 1'b0;
		result.valid = 1'b0;
		mat_we       = 1'b0;
		vec_we       = 1'b0;
		mat_waddr    = x_addr;
		vec_waddr    = x_addr;
		mat_wdata    = rnd_sat(xsum_q);
		vec_wdata    = rnd_sat(xsum_q);
		mat_raddr    = x_addr;
		vec_raddr    = x_addr;
		mul_a        = {mat_rd_q[WORD_BITS-1], mat_rd_q};
		mul_b        = {mat_rd_q[WORD_BITS-1], mat_rd_q};
		unique case (state_q)
			S_IDLE: begin
				elem.ready = 1'b1;
				mat_waddr  = {elem.elem_row, elem.elem_col};
				mat_wdata  = elem.elem_value;
				if (elem.valid) begin
					mat_we = 1'b1;
					if (elem.load_last)
						state_d = S_INIT;
				end
			end
			S_INIT: begin
				vec_we    = 1'b1;
				vec_waddr = cnt_q;
				vec_wdata = (cnt_q[5:3] == cnt_q[2:0]) ? ONE_Q30 : '0;
				if (cnt_q == 6'd63)
					state_d = S_SWEEP_CHK;
			end
			S_SWEEP_CHK: begin
				if (sweep_q == max_sweeps_q)
					state_d = S_OUT_RD;
				else if (n < DIM_W'(2))
					state_d = S_OFF_CMP;
				else
					state_d = S_OFF_RD;
			end
			S_OFF_RD: begin
				mat_raddr = {p_q[IDX_W-1:0], q_q[IDX_W-1:0]};
				state_d   = S_OFF_MUL;
			end
			S_OFF_MUL: state_d = S_OFF_ACC;
			S_OFF_ACC: begin
				if (more_q || more_p)
					state_d = S_OFF_RD;
				else
					state_d = S_OFF_CMP;
			end
			S_OFF_CMP: begin
				if (off_q <= OFF_W'(off_threshold_q))
					state_d = S_OUT_RD;
				else
					state_d = S_ROT_RD0;
			end
			S_ROT_RD0: begin
				mat_raddr = {p_q[IDX_W-1:0], q_q[IDX_W-1:0]};
				state_d   = S_ROT_RD1;
			end
			S_ROT_RD1: begin
				mat_raddr = {q_q[IDX_W-1:0], q_q[IDX_W-1:0]};
				if (mat_rd_q != '0)
					state_d = S_ROT_RD2;
				else if (more_q || more_p)
					state_d = S_ROT_RD0;
				else
					state_d = S_SWEEP_CHK;
			end
			S_ROT_RD2: begin
				mat_raddr = {p_q[IDX_W-1:0], p_q[IDX_W-1:0]};
				state_d   = S_ROT_DE;
			end
			S_ROT_DE: state_d = S_ROT_DD;
			S_ROT_DD: begin
				mul_a   = $signed({3'b000, dd_q});
				mul_b   = $signed({3'b000, dd_q});
				state_d = S_ROT_EE;
			end
			S_ROT_EE: begin
				mul_a   = $signed({3'b000, ee_q});
				mul_b   = $signed({3'b000, ee_q});
				state_d = S_H_LOAD;
			end
			S_H_LOAD: state_d = S_H_SQRT;
			S_H_SQRT: if (sq_done) state_d = S_T_LOAD;
			S_T_LOAD: state_d = S_T_DIV;
			S_T_DIV:  if (dv_done) state_d = S_ROT_TT;
			S_ROT_TT: begin
				mul_a   = $signed({2'b00, nm_q[30:0]});
				mul_b   = $signed({2'b00, nm_q[30:0]});
				state_d = S_R_LOAD;
			end
			S_R_LOAD: state_d = S_R_SQRT;
			S_R_SQRT: if (sq_done) state_d = S_C_LOAD;
			S_C_LOAD: state_d = S_C_DIV;
			S_C_DIV:  if (dv_done) state_d = S_ROT_TC;
			S_ROT_TC: begin
				mul_a   = $signed({2'b00, t_q});
				mul_b   = $signed({2'b00, nm_q[30:0]});
				state_d = S_ROT_S;
			end
			S_ROT_S:  state_d = S_RT_RDX;
			S_RT_RDX: state_d = S_RT_RDY;
			S_RT_RDY: begin
				mat_raddr = y_addr;
				vec_raddr = y_addr;
				state_d   = S_RT_CAP;
			end
			S_RT_CAP: state_d = S_RT_M1;
			S_RT_M1: begin
				mul_a   = $signed({2'b00, c_q});
				mul_b   = {xa_q[WORD_BITS-1], xa_q};
				state_d = S_RT_M2;
			end
			S_RT_M2: begin
				mul_a   = {s_q[WORD_BITS-1], s_q};
				mul_b   = {yb_q[WORD_BITS-1], yb_q};
				state_d = S_RT_M3;
			end
			S_RT_M3: begin
				mul_a   = {s_q[WORD_BITS-1], s_q};
				mul_b   = {xa_q[WORD_BITS-1], xa_q};
				state_d = S_RT_M4;
			end
			S_RT_M4: begin
				mul_a   = $signed({2'b00, c_q});
				mul_b   = {yb_q[WORD_BITS-1], yb_q};
				state_d = S_RT_WX;
			end
			S_RT_WX: begin
				mat_we  = ph_q != PH_VEC;
				vec_we  = ph_q == PH_VEC;
				state_d = S_RT_WY;
			end
			S_RT_WY: begin
				mat_we    = ph_q != PH_VEC;
				vec_we    = ph_q == PH_VEC;
				mat_waddr = y_addr;
				vec_waddr = y_addr;
				mat_wdata = rnd_sat(ysum_q);
				vec_wdata = rnd_sat(ysum_q);
				if (more_k || ph_q != PH_VEC)
					state_d = S_RT_RDX;
				else if (more_q || more_p)
					state_d = S_ROT_RD0;
				else
					state_d = S_SWEEP_CHK;
			end
			S_OUT_RD: begin
				mat_raddr = {j_q[IDX_W-1:0], j_q[IDX_W-1:0]};
				vec_raddr = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
				state_d   = S_OUT_LD;
			end
			S_OUT_LD: state_d = S_OUT_HOLD;
			S_OUT_HOLD: begin
				result.valid = 1'b1;
				if (result.ready)
					state_d = result.out_last ? S_IDLE : S_OUT_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:0];
		case (state_q)
			S_IDLE: begin
				cnt_q   <= '0;
				sweep_q <= '0;
				conv_q  <= 1'b0;
			end
			S_INIT: cnt_q <= cnt_q + 6'd1;
			S_SWEEP_CHK: begin
				off_q <= '0;
				p_q   <= '0;
				q_q   <= DIM_W'(1);
				i_q   <= '0;
				j_q   <= '0;
			end
			S_OFF_ACC: begin
				off_q <= off_q + OFF_W'(prod_q[63:16]);
				if (more_q) begin
					q_q <= q_q + DIM_W'(1);
				end else begin
					p_q <= p_q + DIM_W'(1);
					q_q <= p_q + DIM_W'(2);
				end
			end
			S_OFF_CMP: begin
				p_q <= '0;
				q_q <= DIM_W'(1);
				if (off_q <= OFF_W'(off_threshold_q))
					conv_q <= 1'b1;
			end
			S_ROT_RD1: begin
				apq_q <= mat_rd_q;
				if (mat_rd_q == '0) begin
					if (more_q) begin
						q_q <= q_q + DIM_W'(1);
					end else if (more_p) begin
						p_q <= p_q + DIM_W'(1);
						q_q <= p_q + DIM_W'(2);
					end else begin
						sweep_q <= sweep_q + SWEEP_W'(1);
					end
				end
			end
			S_ROT_RD2: aqq_q <= mat_rd_q;
			S_ROT_DE: begin
				neg_q <= (d_w != '0) && (d_w[32] != e_w[32]);
				dd_q  <= 30'(dm_w >> sh_w);
				ee_q  <= 30'(em_w >> sh_w);
			end
			S_ROT_EE: sqacc_q <= 64'(prod_q);
			S_H_LOAD: begin
				sq_v_q   <= sqacc_q + 64'(prod_q);
				sq_r_q   <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			S_R_LOAD: begin
				t_q      <= nm_q[30:0];
				sq_v_q   <= (64'd1 << 60) + 64'(prod_q);
				sq_r_q   <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			S_H_SQRT, S_R_SQRT: begin
				if (sq_ge) begin
					sq_v_q <= sq_v_q - sq_trial;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			S_T_LOAD: begin
				nm_q  <= {4'b0000, ee_q, 30'b0};
				den_q <= {2'b00, dd_q} + {1'b0, sq_r_q[30:0]};
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_C_LOAD: begin
				nm_q  <= 64'd1 << 60;
				den_q <= {1'b0, sq_r_q[30:0]};
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_T_DIV, S_C_DIV: begin
				rem_q <= dv_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
				nm_q  <= {nm_q[62:0], dv_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			S_ROT_TC: c_q <= nm_q[30:0];
			S_ROT_S: begin
				s_q  <= neg_q ? -$signed({1'b0, prod_q[60:30]}) : $signed({1'b0, prod_q[60:30]});
				ph_q <= PH_COL;
				k_q  <= '0;
			end
			S_RT_RDY: xa_q <= rt_rd;
			S_RT_CAP: yb_q <= rt_rd;
			S_RT_M2:  acc_q <= prod_q;
			S_RT_M3:  xsum_q <= acc_q - prod_q;
			S_RT_M4:  acc_q <= prod_q;
			S_RT_WX:  ysum_q <= acc_q + prod_q;
			S_RT_WY: begin
				if (more_k) begin
					k_q <= k_q + DIM_W'(1);
				end else if (ph_q != PH_VEC) begin
					k_q  <= '0;
					ph_q <= (ph_q == PH_COL) ? PH_ROW : PH_VEC;
				end else if (more_q) begin
					q_q <= q_q + DIM_W'(1);
				end else if (more_p) begin
					p_q <= p_q + DIM_W'(1);
					q_q <= p_q + DIM_W'(2);
				end else begin
					sweep_q <= sweep_q + SWEEP_W'(1);
				end
			end
			S_OUT_LD: begin
				result.vec_row      <= i_q[IDX_W-1:0];
				result.vec_col      <= j_q[IDX_W-1:0];
				result.eigen_value  <= mat_rd_q;
				result.vector_value <= vec_rd_q;
				result.converged    <= conv_q;
				result.sweeps_used  <= sweep_q;
				result.out_last     <= !more_i && ((j_q + DIM_W'(1)) >= n);
			end
			S_OUT_HOLD: begin
				if (result.ready) begin
					if (more_i) begin
						i_q <= i_q + DIM_W'(1);
					end else begin
						i_q <= '0;
						j_q <= j_q + DIM_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
